### sv/u8d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types, constants and decode functions for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned QueueDepthDefault = 4;

    localparam logic [7:0] BomByte0    = 8'hEF;
    localparam logic [7:0] BomByte1    = 8'hBB;
    localparam logic [7:0] BomByte2    = 8'hBF;
    localparam logic [7:0] BadLeadCode = 8'h3F;   // '?'

    localparam logic [7:0] LeadMask2 = 8'hE0;
    localparam logic [7:0] LeadVal2  = 8'hC0;
    localparam logic [7:0] LeadMask3 = 8'hF0;
    localparam logic [7:0] LeadVal3  = 8'hE0;
    localparam logic [7:0] LeadMask4 = 8'hF8;
    localparam logic [7:0] LeadVal4  = 8'hF0;
    localparam logic [7:0] LeadMask5 = 8'hFC;
    localparam logic [7:0] LeadVal5  = 8'hF8;
    localparam logic [7:0] LeadMask6 = 8'hFE;
    localparam logic [7:0] LeadVal6  = 8'hFC;

    // One queue entry: the bytes a single input beat hands to the decoder.
    typedef struct packed {
        logic            clear;   // new file: zero the decoder first
        logic            err;     // foreign byte order mark
        logic            eof;     // flush a partial sequence afterwards
        logic [2:0]      count;   // bytes to decode, 0..4
        logic [3:0][7:0] bytes;   // bytes[0] decoded first
    } job_t;

    typedef struct packed {
        logic [30:0] acc;
        logic [2:0]  rem;
        logic [2:0]  len;
        logic        emit;
        logic [30:0] cp;
        logic [2:0]  cnt;
    } dec_t;

    function automatic dec_t decode_byte(input logic [30:0] acc, input logic [2:0] rem,
                                         input logic [2:0] len, input logic [7:0] b);
        dec_t d;
        d.acc  = acc;
        d.rem  = rem;
        d.len  = len;
        d.emit = 1'b0;
        d.cp   = '0;
        d.cnt  = '0;
        if (rem != 3'd0)
        begin
            d.acc = {acc[24:0], b[5:0]};
            d.rem = rem - 3'd1;
            if (rem == 3'd1)
            begin
                d.emit = 1'b1;
                d.cp   = d.acc;
                d.cnt  = len;
            end
        end
        else if (b[7] == 1'b0)
        begin
            d.emit = 1'b1;
            d.cp   = {23'd0, b};
            d.cnt  = 3'd1;
        end
        else if ((b & LeadMask2) == LeadVal2)
        begin
            d.acc = {26'd0, b[4:0]};
            d.rem = 3'd1;
            d.len = 3'd2;
        end
        else if ((b & LeadMask3) == LeadVal3)
        begin
            d.acc = {27'd0, b[3:0]};
            d.rem = 3'd2;
            d.len = 3'd3;
        end
        else if ((b & LeadMask4) == LeadVal4)
        begin
            d.acc = {28'd0, b[2:0]};
            d.rem = 3'd3;
            d.len = 3'd4;
        end
        else if ((b & LeadMask5) == LeadVal5)
        begin
            d.acc = {29'd0, b[1:0]};
            d.rem = 3'd4;
            d.len = 3'd5;
        end
        else if ((b & LeadMask6) == LeadVal6)
        begin
            d.acc = {30'd0, b[0]};
            d.rem = 3'd5;
            d.len = 3'd6;
        end
        else
        begin
            d.emit = 1'b1;
            d.cp   = {23'd0, BadLeadCode};
            d.cnt  = 3'd1;
        end
        return d;
    endfunction

    // Missing continuation bytes count as zero.
    function automatic logic [30:0] flush_value(input logic [30:0] acc, input logic [2:0] rem);
        logic [4:0] sh;
        sh = {rem, 2'b00} + {1'b0, rem, 1'b0};
        return acc << sh;
    endfunction

    // True when bytes from..count-1 (or the end-of-file flush) still give a result.
    function automatic logic results_ahead(input logic [2:0] rem, input logic [3:0][7:0] bytes,
                                           input logic [2:0] from, input logic [2:0] count,
                                           input logic eof);
        logic [2:0] r;
        logic       any;
        dec_t       d;
        r   = rem;
        any = 1'b0;
        for (int j = 0; j < 4; j++)
        begin
            if (3'(j) >= from && 3'(j) < count)
            begin
                d   = decode_byte(31'd0, r, 3'd0, bytes[j]);
                any = any | d.emit;
                r   = d.rem;
            end
        end
        return any | (eof && r != 3'd0);
    endfunction

    function automatic logic foreign_bom(input logic [3:0][7:0] h);
        logic f;
        f = 1'b0;
        if (h[0] == 8'hFE && h[1] == 8'hFF) f = 1'b1;
        if (h[0] == 8'hFF && h[1] == 8'hFE) f = 1'b1;
        if (h[0] == 8'h00 && h[1] == 8'h00 && h[2] == 8'hFE && h[3] == 8'hFF) f = 1'b1;
        if (h[0] == 8'h0E && h[1] == 8'hFE && h[2] == 8'hFF) f = 1'b1;
        if (h[0] == 8'hDD && h[1] == 8'h73 && h[2] == 8'h66 && h[3] == 8'h73) f = 1'b1;
        if (h[0] == 8'h2B && h[1] == 8'h2F && h[2] == 8'h76 &&
            (h[3] == 8'h38 || h[3] == 8'h39 || h[3] == 8'h2B || h[3] == 8'h2F)) f = 1'b1;
        if (h[0] == 8'hFB && h[1] == 8'hEE && h[2] == 8'h28) f = 1'b1;
        if (h[0] == 8'hF7 && h[1] == 8'h64 && h[2] == 8'h4C) f = 1'b1;
        if (h[0] == 8'h84 && h[1] == 8'h31 && h[2] == 8'h95 && h[3] == 8'h33) f = 1'b1;
        return f;
    endfunction

endpackage
`default_nettype wire

### sv/u8d_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_if
// Byte input channel and decoded result channel.
// ----------------------------------------------------------------------------
interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_file;
    logic       end_of_file;

    modport source (output valid, output data_byte, output first_of_file,
                    output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input first_of_file,
                    input end_of_file, output ready);
endinterface

interface u8d_result_if;
    logic        valid;
    logic        ready;
    logic [30:0] code_point;
    logic [2:0]  byte_count;
    logic        format_error;
    logic        last_of_run;

    modport source (output valid, output code_point, output byte_count,
                    output format_error, output last_of_run, input ready);
    modport sink   (input valid, input code_point, input byte_count,
                    input format_error, input last_of_run, output ready);
endinterface
`default_nettype wire

### sv/u8d_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_front
// Takes input beats, holds and checks the file header, and queues decode jobs.
// ----------------------------------------------------------------------------
module u8d_front
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    u8d_byte_if.sink       byte_in,
    input  wire logic      cfg_we,
    input  wire logic      cfg_wdata,
    input  wire logic      queue_full,
    output logic           push,
    output u8d_pkg::job_t  job
);

    logic            enable_reg;
    logic [2:0]      fill_reg, fill_next;
    logic            done_reg, done_next;
    logic            rej_reg, rej_next;
    logic [3:0][7:0] hb_reg;

    logic            accept;
    logic            sof, eof;
    logic [7:0]      b;
    logic [2:0]      eff_fill, new_fill;
    logic            eff_done, eff_rej;
    logic            header_path, settle, utf8_bom, foreign;
    logic [3:0][7:0] h_cur;

    assign byte_in.ready = !queue_full;
    assign accept        = byte_in.valid && byte_in.ready;
    assign sof           = byte_in.first_of_file;
    assign eof           = byte_in.end_of_file;
    assign b             = byte_in.data_byte;

    // A new file starts from a cleared header state.
    assign eff_fill    = sof ? 3'd0 : fill_reg;
    assign eff_done    = sof ? 1'b0 : done_reg;
    assign eff_rej     = sof ? 1'b0 : rej_reg;
    assign header_path = !eff_done && (enable_reg || eff_fill != 3'd0);
    assign new_fill    = eff_fill + 3'd1;
    assign settle      = header_path && (new_fill == 3'd4 || eof);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < new_fill)
                h_cur[i] = (3'(i) == eff_fill) ? b : hb_reg[i];
            else
                h_cur[i] = 8'h00;
        end
    end

    assign utf8_bom = h_cur[0] == u8d_pkg::BomByte0 && h_cur[1] == u8d_pkg::BomByte1 &&
                      h_cur[2] == u8d_pkg::BomByte2;
    assign foreign  = !utf8_bom && u8d_pkg::foreign_bom(h_cur);

    always_comb
    begin
        job.clear = sof;
        job.err   = 1'b0;
        job.eof   = eof;
        job.count = 3'd0;
        job.bytes = h_cur;
        if (header_path)
        begin
            if (settle)
            begin
                if (utf8_bom)
                begin
                    // drop the UTF-8 mark
                    job.bytes    = '0;
                    job.bytes[0] = h_cur[3];
                    job.count    = new_fill - 3'd3;
                end
                else if (foreign)
                begin
                    job.err = 1'b1;
                    job.eof = 1'b0;
                end
                else
                begin
                    job.count = new_fill;
                end
            end
        end
        else
        begin
            job.bytes    = '0;
            job.bytes[0] = b;
            job.count    = 3'd1;
        end
    end

    // Bytes of a rejected file are dropped.
    assign push = accept && !eff_rej;

    always_comb
    begin
        fill_next = fill_reg;
        done_next = done_reg;
        rej_next  = rej_reg;
        if (accept)
        begin
            fill_next = eff_fill;
            done_next = eff_done;
            rej_next  = eff_rej;
            if (!eff_rej)
            begin
                if (header_path)
                begin
                    if (settle)
                    begin
                        fill_next = 3'd0;
                        done_next = 1'b1;
                        rej_next  = foreign;
                    end
                    else
                    begin
                        fill_next = new_fill;
                    end
                end
                if (eof)
                    done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            fill_reg   <= 3'd0;
            done_reg   <= 1'b0;
            rej_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                enable_reg <= cfg_wdata;
            fill_reg <= fill_next;
            done_reg <= done_next;
            rej_reg  <= rej_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !eff_rej && header_path)
            hb_reg[eff_fill[1:0]] <= b;
    end

endmodule
`default_nettype wire

### sv/u8d_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_fifo
// Short job queue between the header front and the decode back.
// ----------------------------------------------------------------------------
module u8d_fifo
#(
    parameter int unsigned Depth = u8d_pkg::QueueDepthDefault
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire u8d_pkg::job_t  push_job,
    input  wire logic           pop,
    output u8d_pkg::job_t       head_job,
    output logic                head_valid,
    output logic                full
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    u8d_pkg::job_t   mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = count_reg == CntW'(Depth);
    assign head_valid = count_reg != '0;
    assign head_job   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule
`default_nettype wire

### sv/u8d_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_back
// Decodes queued jobs one byte a cycle, while a waiting result does not hold it, into an output register.
// ----------------------------------------------------------------------------
module u8d_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire u8d_pkg::job_t  job,
    input  wire logic           job_valid,
    output logic                pop,
    u8d_result_if.source        result_out
);

    logic [30:0] acc_reg, acc_next;
    logic [2:0]  rem_reg, rem_next;
    logic [2:0]  len_reg, len_next;
    logic [2:0]  idx_reg, idx_next;

    logic        out_valid_reg;
    logic [30:0] out_cp_reg;
    logic [2:0]  out_cnt_reg;
    logic        out_err_reg;
    logic        out_last_reg;

    logic [30:0]   acc_e;
    logic [2:0]    rem_e, len_e;
    logic          byte_step;
    u8d_pkg::dec_t d;

    logic        emit, done, advance, load_ok, load;
    logic [30:0] res_cp;
    logic [2:0]  res_cnt;
    logic        res_err, res_last;

    // A new file clears the decoder before its first step.
    assign acc_e = (job.clear && idx_reg == 3'd0) ? 31'd0 : acc_reg;
    assign rem_e = (job.clear && idx_reg == 3'd0) ? 3'd0 : rem_reg;
    assign len_e = (job.clear && idx_reg == 3'd0) ? 3'd0 : len_reg;

    assign byte_step = idx_reg < job.count;
    assign d = u8d_pkg::decode_byte(acc_e, rem_e, len_e, job.bytes[idx_reg[1:0]]);

    always_comb
    begin
        emit     = 1'b0;
        done     = 1'b1;
        res_cp   = '0;
        res_cnt  = '0;
        res_err  = 1'b0;
        res_last = 1'b1;
        acc_next = acc_e;
        rem_next = rem_e;
        len_next = len_e;
        if (job.err)
        begin
            emit    = 1'b1;
            res_err = 1'b1;
        end
        else if (byte_step)
        begin
            emit     = d.emit;
            res_cp   = d.cp;
            res_cnt  = d.cnt;
            res_last = !u8d_pkg::results_ahead(d.rem, job.bytes, idx_reg + 3'd1,
                                               job.count, job.eof);
            done     = (idx_reg + 3'd1 == job.count) && !(job.eof && d.rem != 3'd0);
            acc_next = d.acc;
            rem_next = d.rem;
            len_next = d.len;
        end
        else if (job.eof && rem_e != 3'd0)
        begin
            // flush the partial sequence at end of file
            emit     = 1'b1;
            res_cp   = u8d_pkg::flush_value(acc_e, rem_e);
            res_cnt  = len_e;
            acc_next = res_cp;
            rem_next = 3'd0;
        end
    end

    assign load_ok = !out_valid_reg || result_out.ready;
    assign advance = job_valid && (!emit || load_ok);
    assign load    = advance && emit;
    assign pop     = advance && done;
    assign idx_next = done ? 3'd0 : idx_reg + 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 31'd0;
            rem_reg       <= 3'd0;
            len_reg       <= 3'd0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                acc_reg <= acc_next;
                rem_reg <= rem_next;
                len_reg <= len_next;
                idx_reg <= idx_next;
            end
            if (load)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_cp_reg   <= res_cp;
            out_cnt_reg  <= res_cnt;
            out_err_reg  <= res_err;
            out_last_reg <= res_last;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.code_point   = out_cp_reg;
    assign result_out.byte_count   = out_cnt_reg;
    assign result_out.format_error = out_err_reg;
    assign result_out.last_of_run  = out_last_reg;

endmodule
`default_nettype wire

### sv/utf8_stream_decoder_with_bom_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder_with_bom_check
// Decodes a UTF-8 byte stream into code points, checking the byte order mark.
// ----------------------------------------------------------------------------
//  channel     dir   handshake       payload
//  byte_in     in    valid/ready     data_byte, first_of_file, end_of_file
//  result_out  out   valid/ready     code_point, byte_count, format_error,
//                                    last_of_run
//  cfg         in    cfg_we          cfg_wdata = header_check_enable
//
//  One beat a cycle is taken while the queue has room; a result is registered
//  in the job queue, then the output register, if nothing waits ahead. The
//  decode unit takes one job byte a cycle while the sink keeps up, and a step
//  on an empty job (a held header beat); a settled header has up to four bytes,
//  an end-of-file flush one step. The job queue (QueueDepth entries) absorbs short
//  bursts and sink stalls; reset is asynchronous, active low, and leaves the header check on.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_with_bom_check
#(
    parameter int unsigned QueueDepth = u8d_pkg::QueueDepthDefault
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    u8d_byte_if.sink      byte_in,
    u8d_result_if.source  result_out,
    input  wire logic     cfg_we,
    input  wire logic     cfg_wdata
);

    u8d_pkg::job_t push_job;
    u8d_pkg::job_t head_job;
    logic          push, pop, head_valid, queue_full;

    u8d_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    u8d_fifo #(.Depth(QueueDepth)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_job   (head_job),
        .head_valid (head_valid),
        .full       (queue_full)
    );

    u8d_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (head_job),
        .job_valid  (head_valid),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule
`default_nettype wire
